// File: sv/sstf_pkg.sv
package sstf_pkg;

	typedef enum logic [1:0] {
		ST_ADDED      = 2'd0,
		ST_DISPATCHED = 2'd1,
		ST_EMPTY      = 2'd2,
		ST_FULL       = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_SHIFT_UP_RD,
		S_SHIFT_UP_WR,
		S_INSERT,
		S_DSP_RD,
		S_DSP_NB,
		S_DSP_NB2,
		S_DSP_DECIDE,
		S_SHIFT_DN_RD,
		S_SHIFT_DN_WR,
		S_OUT
	} state_t;

	localparam int SECTOR_W = 48;
	localparam int TAG_W    = 8;
	localparam int ENTRY_W  = SECTOR_W + TAG_W;

endpackage

// File: sv/sstf_ram.sv
module sstf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sv/sstf_request_scheduler.sv
// Channel   Dir   Payload
// s_axis    in    tuser: mode; tdata[47:0] req_sector, [55:48] req_tag
// m_axis    out   tdata[1:0] status, [49:2] out_sector, [57:50] out_tag,
//                 [64:58] pending_count, zero fill to 72 bits
//
// Each item walks the sorted array in the entry memory: an add scans up
// for its slot, then shifts the entries above it up; a dispatch reads the
// current entry and both neighbours, then shifts the entries above it down.
// An add to a full queue or a dispatch from an empty one skips the walk.
// Reset clears count, position and output valid; memory contents stay as is.
// One item is in work at a time; s_axis_tready is low until the result
// register is free again. m_axis stalls hold the result.
module sstf_request_scheduler #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,   // req_sector, req_tag
	input  logic        s_axis_tuser,   // mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata    // status, out_sector, out_tag, pending_count
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int EW = sstf_pkg::ENTRY_W;
	localparam int SW = sstf_pkg::SECTOR_W;

	sstf_pkg::state_t state_q, state_d;

	logic [CW-1:0] count_q;
	logic [AW-1:0] pos_q;
	logic [CW-1:0] idx_q;
	logic [SW-1:0] sec_q;
	logic [7:0]    tag_q;
	logic [SW-1:0] cur_q, lo_q;
	logic [7:0]    curtag_q;
	logic [AW-1:0] p_q;
	logic          ovalid_q;
	logic [1:0]    ost_q;
	logic [SW-1:0] osec_q;
	logic [7:0]    otag_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [EW-1:0] wdata, rdata;
	logic [SW-1:0] rsec;

	sstf_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	assign rsec = rdata[SW-1:0];
	assign s_axis_tready = (state_q == sstf_pkg::S_IDLE) && !ovalid_q;
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = {7'd0, 7'(count_q), otag_q, osec_q, ost_q};

	logic [SW-1:0] d_lo, d_hi;
	assign d_lo = (cur_q >= lo_q) ? cur_q - lo_q : lo_q - cur_q;
	assign d_hi = (rsec >= cur_q) ? rsec - cur_q : cur_q - rsec;

	always_comb begin
		state_d = state_q;
		we = 1'b0;
		waddr = idx_q[AW-1:0];
		wdata = rdata;
		case (state_q)
			sstf_pkg::S_IDLE: begin
				if (s_axis_tvalid && s_axis_tready) begin
					if (!s_axis_tuser) begin
						if (count_q >= CW'(QUEUE_DEPTH)) begin
							state_d = sstf_pkg::S_OUT;
						end else if (count_q == '0) begin
							state_d = sstf_pkg::S_INSERT;
						end else begin
							state_d = sstf_pkg::S_SCAN_RD;
						end
					end else if (count_q == '0) begin
						state_d = sstf_pkg::S_OUT;
					end else begin
						state_d = sstf_pkg::S_DSP_RD;
					end
				end
			end
			sstf_pkg::S_SCAN_RD: state_d = sstf_pkg::S_SCAN_CHK;
			sstf_pkg::S_SCAN_CHK: begin
				if (rsec > sec_q) begin
					state_d = sstf_pkg::S_SHIFT_UP_RD;
				end else if (idx_q + 1'b1 == count_q) begin
					state_d = sstf_pkg::S_INSERT;
				end else begin
					state_d = sstf_pkg::S_SCAN_RD;
				end
			end
			sstf_pkg::S_SHIFT_UP_RD: state_d = sstf_pkg::S_SHIFT_UP_WR;
			sstf_pkg::S_SHIFT_UP_WR: begin
				we = 1'b1;
				waddr = AW'(idx_q);
				if (idx_q - 1'b1 == CW'(p_q)) begin
					state_d = sstf_pkg::S_INSERT;
				end else begin
					state_d = sstf_pkg::S_SHIFT_UP_RD;
				end
			end
			sstf_pkg::S_INSERT: begin
				we = 1'b1;
				wdata = {tag_q, sec_q};
				state_d = sstf_pkg::S_OUT;
			end
			sstf_pkg::S_DSP_RD:  state_d = sstf_pkg::S_DSP_NB;
			sstf_pkg::S_DSP_NB:  state_d = sstf_pkg::S_DSP_NB2;
			sstf_pkg::S_DSP_NB2: state_d = sstf_pkg::S_DSP_DECIDE;
			sstf_pkg::S_DSP_DECIDE: begin
				if (CW'(p_q) + 1'b1 >= count_q) begin
					state_d = sstf_pkg::S_OUT;
				end else begin
					state_d = sstf_pkg::S_SHIFT_DN_RD;
				end
			end
			sstf_pkg::S_SHIFT_DN_RD: state_d = sstf_pkg::S_SHIFT_DN_WR;
			sstf_pkg::S_SHIFT_DN_WR: begin
				we = 1'b1;
				waddr = AW'(idx_q - 1'b1);
				if (idx_q + 1'b1 >= count_q) begin
					state_d = sstf_pkg::S_OUT;
				end else begin
					state_d = sstf_pkg::S_SHIFT_DN_RD;
				end
			end
			sstf_pkg::S_OUT: state_d = sstf_pkg::S_IDLE;
			default: state_d = sstf_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sstf_pkg::S_IDLE;
			count_q  <= '0;
			pos_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == sstf_pkg::S_OUT) begin
				ovalid_q <= 1'b1;
			end else if (ovalid_q && m_axis_tready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				sstf_pkg::S_IDLE: begin
					if (s_axis_tvalid && s_axis_tready) begin
						sec_q  <= s_axis_tdata[SW-1:0];
						tag_q  <= s_axis_tdata[55:48];
						osec_q <= '0;
						otag_q <= '0;
						if (!s_axis_tuser) begin
							idx_q <= '0;
							if (count_q >= CW'(QUEUE_DEPTH)) begin
								ost_q <= sstf_pkg::ST_FULL;
							end
						end else if (count_q == '0) begin
							ost_q <= sstf_pkg::ST_EMPTY;
						end else begin
							p_q <= (CW'(pos_q) >= count_q) ? AW'(count_q - 1'b1) : pos_q;
							idx_q <= (CW'(pos_q) >= count_q) ? count_q - 1'b1 : CW'(pos_q);
						end
					end
				end
				// find first slot with sector above the new one
				sstf_pkg::S_SCAN_CHK: begin
					if (rsec > sec_q) begin
						p_q <= idx_q[AW-1:0];
						idx_q <= count_q;
					end else if (idx_q + 1'b1 == count_q) begin
						p_q <= AW'(count_q);
						idx_q <= count_q;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				// read k-1, write k; stop at the insert slot
				sstf_pkg::S_SHIFT_UP_WR: begin
					idx_q <= idx_q - 1'b1;
				end
				sstf_pkg::S_INSERT: begin
					ost_q <= sstf_pkg::ST_ADDED;
					if (count_q == '0) begin
						pos_q <= '0;
					end else if (CW'(idx_q[AW-1:0]) <= CW'(pos_q)
						&& CW'(pos_q) + 1'b1 < count_q + 1'b1) begin
						pos_q <= pos_q + 1'b1;
					end
					count_q <= count_q + 1'b1;
				end
				sstf_pkg::S_DSP_NB: begin
					cur_q <= rsec;
					curtag_q <= rdata[EW-1:SW];
				end
				sstf_pkg::S_DSP_NB2: begin
					lo_q <= rsec;
				end
				sstf_pkg::S_DSP_DECIDE: begin
					// rdata holds the upper neighbour here
					ost_q <= sstf_pkg::ST_DISPATCHED;
					osec_q <= cur_q;
					otag_q <= curtag_q;
					if (count_q == CW'(1)) begin
						pos_q <= '0;
					end else if (p_q == '0) begin
						pos_q <= p_q;
					end else if (CW'(p_q) + 1'b1 >= count_q) begin
						pos_q <= p_q - 1'b1;
					end else begin
						pos_q <= (d_lo < d_hi) ? p_q - 1'b1 : p_q;
					end
					idx_q <= CW'(p_q) + 1'b1;
					if (CW'(p_q) + 1'b1 >= count_q) begin
						count_q <= count_q - 1'b1;
					end
				end
				sstf_pkg::S_SHIFT_DN_WR: begin
					if (idx_q + 1'b1 >= count_q) begin
						count_q <= count_q - 1'b1;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// read address per state: shift up reads k-1, dispatch reads p, p-1, p+1
	logic [AW-1:0] raddr_sel;
	always_comb begin
		case (state_q)
			sstf_pkg::S_SHIFT_UP_RD: raddr_sel = AW'(idx_q - 1'b1);
			sstf_pkg::S_DSP_RD:      raddr_sel = p_q;
			sstf_pkg::S_DSP_NB:      raddr_sel = p_q - 1'b1;
			sstf_pkg::S_DSP_NB2:     raddr_sel = p_q + 1'b1;
			sstf_pkg::S_DSP_DECIDE:  raddr_sel = p_q + 1'b1;
			default:                 raddr_sel = idx_q[AW-1:0];
		endcase
	end

	assign raddr = raddr_sel;

`ifndef SYNTH
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH)) else $error("count overflow");
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> state_q == sstf_pkg::S_IDLE) else $error("ready while busy");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata)) else $error("result moved");
`endif

endmodule

// File: test/sstf_request_scheduler_tb.sv
module sstf_request_scheduler_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 64;
	localparam int RANDOM_ITEMS = 1200;
	localparam int STALL_LIMIT = 20000;
	localparam logic MODE_ADD = 1'b0;
	localparam logic MODE_DISPATCH = 1'b1;

	typedef struct packed {
		sstf_pkg::status_t status;
		logic [47:0] sector;
		logic [7:0] tag;
		logic [6:0] count;
	} sched_result_t;

	typedef struct {
		logic mode;
		logic [47:0] sector;
		logic [7:0] tag;
		bit typed;
		sstf_pkg::status_t status;
		logic [47:0] exp_sector;
		logic [7:0] exp_tag;
		logic [6:0] exp_count;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [55:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;

	// shadow of the sorted request list
	logic [47:0] q_sector[DEPTH];
	logic [7:0] q_tag[DEPTH];
	int q_count = 0;
	int q_pos = 0;

	sched_result_t pending_results[$];
	int errors = 0;
	int send_idle = 34;
	int recv_idle = 86;
	int quiet_cycles = 0;
	stim_row_t rows[$];

	always #6 clk = ~clk;

	sstf_request_scheduler #(.QUEUE_DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	function automatic sched_result_t schedule_step(logic mode, logic [47:0] sector,
			logic [7:0] tag);
		sched_result_t r;
		int slot;
		int p;
		bit take_lower;
		logic [47:0] d_lo;
		logic [47:0] d_hi;
		r = '{sstf_pkg::ST_ADDED, 48'd0, 8'd0, 7'd0};
		if (mode == MODE_ADD) begin
			if (q_count >= DEPTH) begin
				r.status = sstf_pkg::ST_FULL;
			end else if (q_count == 0) begin
				q_sector[0] = sector;
				q_tag[0] = tag;
				q_count = 1;
				q_pos = 0;
			end else begin
				slot = 0;
				while (slot < q_count && q_sector[slot] <= sector)
					slot++;
				for (int k = q_count; k > slot; k--) begin
					q_sector[k] = q_sector[k - 1];
					q_tag[k] = q_tag[k - 1];
				end
				q_sector[slot] = sector;
				q_tag[slot] = tag;
				q_count++;
				if (slot <= q_pos && q_pos + 1 < q_count)
					q_pos++;
			end
		end else if (q_count == 0) begin
			r.status = sstf_pkg::ST_EMPTY;
		end else begin
			p = (q_pos >= q_count) ? q_count - 1 : q_pos;
			r.status = sstf_pkg::ST_DISPATCHED;
			r.sector = q_sector[p];
			r.tag = q_tag[p];
			if (q_count == 1) begin
				q_count = 0;
				q_pos = 0;
			end else begin
				if (p == 0) begin
					take_lower = 1'b0;
				end else if (p + 1 >= q_count) begin
					take_lower = 1'b1;
				end else begin
					d_lo = r.sector - q_sector[p - 1];
					d_hi = q_sector[p + 1] - r.sector;
					take_lower = d_lo < d_hi;
				end
				for (int k = p; k + 1 < q_count; k++) begin
					q_sector[k] = q_sector[k + 1];
					q_tag[k] = q_tag[k + 1];
				end
				q_count--;
				q_pos = take_lower ? p - 1 : p;
			end
		end
		r.count = 7'(q_count);
		return r;
	endfunction

	// predict at acceptance, in order
	task automatic send_item(logic mode, logic [47:0] sector, logic [7:0] tag);
		if ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= mode;
		s_axis_tdata <= {tag, sector};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pending_results.push_back(schedule_step(mode, sector, tag));
	endtask

	always @(posedge clk) begin
		sched_result_t got;
		sched_result_t want;
		if (arst_n) begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle);
			if (m_axis_tvalid && m_axis_tready) begin
				got = {m_axis_tdata[1:0], m_axis_tdata[49:2], m_axis_tdata[57:50],
					m_axis_tdata[64:58]};
				if (pending_results.size() == 0) begin
					$error("unexpected result %h", m_axis_tdata);
					errors++;
				end else begin
					want = pending_results.pop_front();
					if (got.status !== want.status) begin
						$error("status expected %0d actual %0d", want.status, got.status);
						errors++;
					end
					if (got.sector !== want.sector) begin
						$error("out_sector expected %h actual %h", want.sector, got.sector);
						errors++;
					end
					if (got.tag !== want.tag) begin
						$error("out_tag expected %h actual %h", want.tag, got.tag);
						errors++;
					end
					if (got.count !== want.count) begin
						$error("pending_count expected %0d actual %0d", want.count,
							got.count);
						errors++;
					end
				end
			end
		end
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("sstf_request_scheduler_tb failed");
			$finish;
		end
	end

	function automatic stim_row_t row(logic mode, logic [47:0] sector, logic [7:0] tag,
			bit typed = 1'b0, sstf_pkg::status_t st = sstf_pkg::ST_ADDED,
			logic [47:0] es = '0, logic [7:0] et = '0, logic [6:0] ec = '0);
		stim_row_t r;
		r = '{mode, sector, tag, typed, st, es, et, ec};
		return r;
	endfunction

	task automatic send_row(stim_row_t r);
		sched_result_t typed_r;
		send_item(r.mode, r.sector, r.tag);
		// typed rows expect the typed value from the block
		if (r.typed) begin
			typed_r = '{r.status, r.exp_sector, r.exp_tag, r.exp_count};
			pending_results[pending_results.size() - 1] = typed_r;
		end
	endtask

	task automatic drain();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic random_phase(int n);
		logic [47:0] base;
		logic [47:0] sec;
		for (int i = 0; i < n; i++) begin
			base = 48'({$urandom, $urandom});
			case ($urandom_range(9))
				0: sec = 48'({$urandom, $urandom});
				1: sec = 48'hFFFF_FFFF_FFFF - $urandom_range(3);
				2: sec = 48'($urandom_range(3));
				default: sec = 48'd1000 + $urandom_range(400);
			endcase
			if (q_count > 56 || ($urandom_range(99) < 45))
				send_item(MODE_DISPATCH, base, 8'($urandom));
			else
				send_item(MODE_ADD, sec, 8'($urandom));
		end
	endtask

	initial begin
		rows.push_back(row(MODE_DISPATCH, 48'hFFFF_FFFF_FFFF, 8'hFF, 1'b1,
			sstf_pkg::ST_EMPTY, '0, '0, '0));
		rows.push_back(row(MODE_ADD, 48'd500, 8'h01, 1'b1, sstf_pkg::ST_ADDED,
			'0, '0, 7'd1));
		rows.push_back(row(MODE_DISPATCH, '0, '0, 1'b1, sstf_pkg::ST_DISPATCHED,
			48'd500, 8'h01, '0));
		rows.push_back(row(MODE_ADD, 48'd500, 8'h10));
		rows.push_back(row(MODE_ADD, 48'd500, 8'h11));
		rows.push_back(row(MODE_ADD, 48'd0, 8'h00));
		rows.push_back(row(MODE_ADD, 48'hFFFF_FFFF_FFFF, 8'hFF));
		rows.push_back(row(MODE_ADD, 48'd700, 8'h20));
		rows.push_back(row(MODE_ADD, 48'd300, 8'h21));
		rows.push_back(row(MODE_ADD, 48'hAAAA_AAAA_AAAA, 8'h55));
		rows.push_back(row(MODE_ADD, 48'h5555_5555_5555, 8'hAA));
		for (int i = 0; i < 10; i++)
			rows.push_back(row(MODE_DISPATCH, '0, '0));
		for (int i = 0; i < 3; i++)
			rows.push_back(row(MODE_ADD, 48'd600 + 48'(100 * i), 8'(8'h30 + i)));
		rows.push_back(row(MODE_DISPATCH, '0, '0));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i])
			send_row(rows[i]);
		// fill to full, then overflow
		while (q_count < DEPTH)
			send_item(MODE_ADD, 48'({$urandom, $urandom}), 8'($urandom));
		send_item(MODE_ADD, 48'd1, 8'h01);
		send_item(MODE_ADD, 48'hFFFF_FFFF_FFFF, 8'hFF);
		while (q_count > 0)
			send_item(MODE_DISPATCH, '0, '0);
		random_phase(RANDOM_ITEMS / 3);
		send_idle = 86;
		recv_idle = 34;
		random_phase(RANDOM_ITEMS / 3);
		send_idle = 0;
		recv_idle = 0;
		random_phase(RANDOM_ITEMS / 3);
		s_axis_tvalid <= 1'b0;
		drain();
		if (errors == 0)
			$display("sstf_request_scheduler_tb passed");
		else
			$display("sstf_request_scheduler_tb failed");
		$finish;
	end
endmodule
